/* hdl/bls_pkg.sv */
// Shared types and constants for the bounded LIFO stack.
`timescale 1ns / 1ps
`default_nettype none
package bls_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;

    localparam int IN_W = ((ACTION_W + VALUE_W + POS_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_READ   = 2'd2,
        ACT_SEARCH = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PUSH = 2'd1,
        CELL_ROT  = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_SCAN = 1'b1
    } fsm_t;

endpackage
`default_nettype wire

/* hdl/bls_cell.sv */
// One storage cell of the stack chain; cell 0 holds the top.
`timescale 1ns / 1ps
`default_nettype none
module bls_cell #(
    parameter int DATA_WIDTH = bls_pkg::DATA_WIDTH_DEF
) (
    input  wire                   aclk,
    input  bls_pkg::cell_ctrl_t   ctrl,
    input  wire  [DATA_WIDTH-1:0] up_word,
    input  wire  [DATA_WIDTH-1:0] down_word,
    output logic [DATA_WIDTH-1:0] word_q
);
    import bls_pkg::*;

    logic [DATA_WIDTH-1:0] word_reg;

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            CELL_PUSH: word_reg <= up_word;
            CELL_ROT:  word_reg <= down_word;
            default:   word_reg <= word_reg;
        endcase
    end

    assign word_q = word_reg;

endmodule
`default_nettype wire

/* hdl/bls_ctrl.sv */
// Stack controller: fill count, scan sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module bls_ctrl #(
    parameter int DEPTH      = bls_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bls_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  bls_pkg::action_t             action,
    input  wire  [bls_pkg::VALUE_W-1:0]  value,
    input  wire  [bls_pkg::POS_W-1:0]    position,
    output logic                         out_valid,
    input  wire                          out_ready,
    output bls_pkg::status_t             status,
    output logic [bls_pkg::VALUE_W-1:0]  data,
    output logic                         found,
    output logic [CNT_W-1:0]             count,
    input  wire  [DATA_WIDTH-1:0]        top_word,
    input  wire  [DATA_WIDTH-1:0]        next_word,
    output logic [DATA_WIDTH-1:0]        push_word,
    output bls_pkg::cell_ctrl_t          cell_ctrl
);
    import bls_pkg::*;

    localparam int KW    = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    function automatic logic [VALUE_W-1:0] to_out(input logic [DATA_WIDTH-1:0] w);
        logic [63:0] ext;
        ext = 64'($signed(w));
        return ext[VALUE_W-1:0];
    endfunction

    fsm_t                  state_reg, state_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    action_t               act_reg, act_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  hit_reg, hit_next;
    logic [DATA_WIDTH-1:0] rd_reg, rd_next;
    logic                  ov_reg, ov_next;
    status_t               os_reg, os_next;
    logic [VALUE_W-1:0]    od_reg, od_next;
    logic                  of_reg, of_next;
    logic [CNT_W-1:0]      oc_reg, oc_next;
    logic [63:0]           value_ext;
    logic                  accept;

    assign value_ext = {32'b0, value};
    assign push_word = value_ext[DATA_WIDTH-1:0];
    assign accept    = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
            fill_reg  <= '0;
            ov_reg    <= 1'b0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ov_reg    <= ov_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg <= act_next;
        key_reg <= key_next;
        pos_reg <= pos_next;
        hit_reg <= hit_next;
        rd_reg  <= rd_next;
        os_reg  <= os_next;
        od_reg  <= od_next;
        of_reg  <= of_next;
        oc_reg  <= oc_next;
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        fill_next    = fill_reg;
        act_next     = act_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        hit_next     = hit_reg;
        rd_next      = rd_reg;
        ov_next      = ov_reg && !out_ready;
        os_next      = os_reg;
        od_next      = od_reg;
        of_next      = of_reg;
        oc_next      = oc_reg;
        in_ready     = 1'b0;
        cell_ctrl.op = CELL_HOLD;
        case (state_reg)
            FSM_IDLE: begin
                in_ready = !ov_reg || out_ready;
                if (accept) begin
                    os_next = ST_OK;
                    od_next = '0;
                    of_next = 1'b0;
                    oc_next = fill_reg;
                    case (action)
                        ACT_PUSH: begin
                            ov_next = 1'b1;
                            if (fill_reg == CNT_W'(DEPTH)) begin
                                os_next = ST_FULL;
                                od_next = to_out(top_word);
                            end else begin
                                cell_ctrl.op = CELL_PUSH;
                                fill_next    = fill_reg + 1'b1;
                                oc_next      = fill_reg + 1'b1;
                                od_next      = to_out(push_word);
                            end
                        end
                        ACT_POP: begin
                            ov_next = 1'b1;
                            if (fill_reg == '0) begin
                                os_next = ST_EMPTY;
                            end else begin
                                cell_ctrl.op = CELL_ROT;
                                fill_next    = fill_reg - 1'b1;
                                oc_next      = fill_reg - 1'b1;
                                if (fill_reg > CNT_W'(1)) begin
                                    od_next = to_out(next_word);
                                end
                            end
                        end
                        ACT_READ: begin
                            if (position == '0 || CMP_W'(position) > CMP_W'(fill_reg)) begin
                                ov_next = 1'b1;
                                os_next = ST_RANGE;
                            end else begin
                                state_next = FSM_SCAN;
                            end
                        end
                        default: begin
                            state_next = FSM_SCAN;
                        end
                    endcase
                    act_next = action;
                    key_next = push_word;
                    pos_next = position;
                    hit_next = 1'b0;
                    k_next   = '0;
                end
            end
            FSM_SCAN: begin
                cell_ctrl.op = CELL_ROT;
                k_next       = k_reg + 1'b1;
                if (act_reg == ACT_READ) begin
                    if (CMP_W'(k_reg) + CMP_W'(1) == CMP_W'(pos_reg)) begin
                        rd_next = top_word;
                    end
                end else if (CNT_W'(k_reg) < fill_reg && top_word == key_reg) begin
                    hit_next = 1'b1;
                end
                if (k_reg == KW'(DEPTH - 1)) begin
                    state_next = FSM_IDLE;
                    ov_next    = 1'b1;
                    os_next    = ST_OK;
                    oc_next    = fill_reg;
                    if (act_reg == ACT_READ) begin
                        of_next = 1'b0;
                        if (CMP_W'(k_reg) + CMP_W'(1) == CMP_W'(pos_reg)) begin
                            od_next = to_out(top_word);
                        end else begin
                            od_next = to_out(rd_reg);
                        end
                    end else begin
                        of_next = hit_next;
                        od_next = hit_next ? to_out(key_reg) : '0;
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign status    = os_reg;
    assign data      = od_reg;
    assign found     = of_reg;
    assign count     = oc_reg;

endmodule
`default_nettype wire

/* hdl/bounded_lifo_stack.sv */
// Top level of the bounded LIFO stack: controller and chain of storage cells.
`timescale 1ns / 1ps
`default_nettype none
// The stack is a row of DEPTH cells, cell 0 holding the top. Push shifts the
// row down and pop rotates it up; each, like a read with a bad position, is
// done in its accept cycle. A valid read and every search rotate the whole
// row once around, one cell per cycle, looking at cell 0, and no new item is
// taken until the row is back in place and the result is loaded. A result waits
// in an output register and the next item is taken in the cycle that result
// leaves.
module bounded_lifo_stack #(
    parameter int DEPTH      = bls_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bls_pkg::DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int OUT_W     = ((bls_pkg::STATUS_W + bls_pkg::VALUE_W + 1 + CNT_W + 7) / 8) * 8
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    // action[1:0], value[33:2], position[38:34], zero pad
    input  wire  [bls_pkg::IN_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  wire                     m_tready,
    // status[1:0], data[33:2], found[34], count[34+CNT_W:35], zero pad
    output logic [OUT_W-1:0]        m_tdata
);
    import bls_pkg::*;

    localparam int V_LO = ACTION_W;
    localparam int P_LO = ACTION_W + VALUE_W;
    localparam int F_LO = STATUS_W + VALUE_W;
    localparam int C_LO = F_LO + 1;
    localparam int PAD  = OUT_W - C_LO - CNT_W;

    action_t               action;
    status_t               status;
    logic [VALUE_W-1:0]    data;
    logic                  found;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] push_word;
    cell_ctrl_t            cell_ctrl;
    logic [DATA_WIDTH-1:0] cell_q [DEPTH];

    assign action = action_t'(s_tdata[ACTION_W-1:0]);

    bls_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .action    (action),
        .value     (s_tdata[P_LO-1:V_LO]),
        .position  (s_tdata[P_LO+POS_W-1:P_LO]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .data      (data),
        .found     (found),
        .count     (count),
        .top_word  (cell_q[0]),
        .next_word (cell_q[1]),
        .push_word (push_word),
        .cell_ctrl (cell_ctrl)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        bls_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .up_word   ((i == 0) ? push_word : cell_q[(i + DEPTH - 1) % DEPTH]),
            .down_word (cell_q[(i + 1) % DEPTH]),
            .word_q    (cell_q[i])
        );
    end

    if (PAD > 0) begin : g_pad
        assign m_tdata = {{PAD{1'b0}}, count, found, data, status};
    end else begin : g_nopad
        assign m_tdata = {count, found, data, status};
    end

endmodule
`default_nettype wire

/* sim/bounded_lifo_stack_tb.sv */
// Self-checking testbench for the bounded LIFO stack: random actions, predicted results.
`timescale 1ns / 1ps
module bounded_lifo_stack_tb;
    import bls_pkg::*;

    localparam int DEPTH    = DEPTH_DEF;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OUT_W    = ((STATUS_W + VALUE_W + 1 + CNT_W + 7) / 8) * 8;
    localparam int N_RANDOM = 1300;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;

    typedef struct {
        action_t             act;
        logic signed [31:0]  value;
        logic [POS_W-1:0]    pos;
        logic                drain_first;
    } stack_op_t;

    typedef struct {
        status_t             status;
        logic signed [31:0]  data;
        logic                found;
        logic [CNT_W-1:0]    count;
    } stack_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    stack_op_t     action_queue[$];
    stack_result_t pending_results[$];
    stack_op_t     cur_op;

    // predictor state
    logic signed [31:0] stk_mem [DEPTH];
    int                 stk_fill = 0;

    int  err_count    = 0;
    int  results_seen = 0;
    int  idle_cycles  = 0;
    logic s_fire = 1'b0;

    int tx_gap = 0, tx_calm = 0;
    int rx_gap = 0, rx_calm = 0, rx_last_seen = 0;
    int hold_left = 0, next_hold_at = 300;

    bounded_lifo_stack u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic stack_result_t stack_apply(stack_op_t op);
        stack_result_t r;
        r.status = ST_OK;
        r.data   = '0;
        r.found  = 1'b0;
        case (op.act)
            ACT_PUSH: begin
                if (stk_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stk_mem[stk_fill] = op.value;
                    stk_fill++;
                end
                r.data = stk_mem[stk_fill - 1];
            end
            ACT_POP: begin
                if (stk_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    stk_fill--;
                    if (stk_fill > 0) r.data = stk_mem[stk_fill - 1];
                end
            end
            ACT_READ: begin
                if (op.pos == 0 || op.pos > stk_fill) r.status = ST_RANGE;
                else r.data = stk_mem[stk_fill - op.pos];
            end
            default: begin
                for (int i = 0; i < stk_fill; i++)
                    if (stk_mem[i] == op.value) r.found = 1'b1;
                if (r.found) r.data = op.value;
            end
        endcase
        r.count = stk_fill[CNT_W-1:0];
        return r;
    endfunction

    // mostly short gaps, a few long ones, and stretches with none
    function automatic int pick_gap(ref int calm);
        int p;
        p = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (p < 3) calm = $urandom_range(20, 80);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic flag_mismatch(string what);
        err_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // sender
    always @(negedge aclk) begin : drive
        logic      nv;
        stack_op_t op;
        if (aresetn && (!s_tvalid || s_fire)) begin
            nv = 1'b0;
            if (s_fire) tx_gap = pick_gap(tx_calm);
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (action_queue.size() > 0 &&
                         !(action_queue[0].drain_first && pending_results.size() != 0)) begin
                op = action_queue.pop_front();
                cur_op  <= op;
                s_tdata <= {{(IN_W - ACTION_W - VALUE_W - POS_W){1'b0}},
                            op.pos, op.value, op.act};
                nv = 1'b1;
            end
            s_tvalid <= nv;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (results_seen != rx_last_seen) begin
                rx_last_seen = results_seen;
                rx_gap = pick_gap(rx_calm);
            end
            if (hold_left == 0 && next_hold_at <= 800 && results_seen >= next_hold_at) begin
                hold_left = LONG_HOLD;
                next_hold_at += 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result check, prediction and watchdog
    always @(posedge aclk) begin : scoreboard
        stack_result_t got, exp_r;
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tdata[1:0]);
                got.data   = m_tdata[33:2];
                got.found  = m_tdata[34];
                got.count  = m_tdata[35 +: CNT_W];
                results_seen++;
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with no item outstanding");
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got.status !== exp_r.status)
                        flag_mismatch($sformatf("status got %0d exp %0d",
                                                got.status, exp_r.status));
                    if (got.data !== exp_r.data)
                        flag_mismatch($sformatf("data got %0d exp %0d",
                                                got.data, exp_r.data));
                    if (got.found !== exp_r.found)
                        flag_mismatch($sformatf("found got %0b exp %0b",
                                                got.found, exp_r.found));
                    if (got.count !== exp_r.count)
                        flag_mismatch($sformatf("count got %0d exp %0d",
                                                got.count, exp_r.count));
                end
            end
            if (s_tvalid && s_tready) pending_results.push_back(stack_apply(cur_op));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic add_op(action_t act, logic signed [31:0] value, int pos,
                          logic drain = 1'b0);
        stack_op_t op;
        op.act         = act;
        op.value       = value;
        op.pos         = pos[POS_W-1:0];
        op.drain_first = drain;
        action_queue.push_back(op);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4:          return 32'sd0;
            5:          return -32'sd1;
            6:          return 32'sh8000_0000;
            7:          return 32'sh7fff_ffff;
            default:    return $urandom_range(0, 7);
        endcase
    endfunction

    initial begin : stimulus
        int gen_fill, mode, p, pos;
        action_t act;

        // empty stack corner cases
        add_op(ACT_POP, 0, 1);
        add_op(ACT_READ, 0, 1);
        add_op(ACT_SEARCH, 0, 1);
        // value extremes
        add_op(ACT_PUSH, 32'sh7fff_ffff, 0);
        add_op(ACT_PUSH, 32'sh8000_0000, 31);
        add_op(ACT_PUSH, 32'sd0, 1);
        add_op(ACT_PUSH, -32'sd1, 16);
        // read positions: zero, top, bottom, past count, max field
        add_op(ACT_READ, 0, 0);
        add_op(ACT_READ, 0, 1);
        add_op(ACT_READ, 0, 4);
        add_op(ACT_READ, 0, 5);
        add_op(ACT_READ, 0, 31);
        // search: zero key held, extreme held, absent key
        add_op(ACT_SEARCH, 32'sd0, 0);
        add_op(ACT_SEARCH, 32'sh8000_0000, 0);
        add_op(ACT_SEARCH, 32'sd5, 0);
        // fill to full, then overflow and deep reads
        for (int i = 0; i < 12; i++) add_op(ACT_PUSH, $urandom, 0);
        add_op(ACT_PUSH, 32'sd9, 0);
        add_op(ACT_READ, 0, 16);
        add_op(ACT_READ, 0, 17);
        add_op(ACT_SEARCH, 32'sh7fff_ffff, 0);
        add_op(ACT_POP, 0, 0);
        gen_fill = 15;

        mode = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 40 == 0) mode = $urandom_range(0, 2);
            p = $urandom_range(0, 99);
            case (mode)
                0:       act = p < 70 ? ACT_PUSH : p < 80 ? ACT_POP :
                               p < 90 ? ACT_READ : ACT_SEARCH;
                1:       act = p < 15 ? ACT_PUSH : p < 80 ? ACT_POP :
                               p < 90 ? ACT_READ : ACT_SEARCH;
                default: act = p < 30 ? ACT_PUSH : p < 55 ? ACT_POP :
                               p < 80 ? ACT_READ : ACT_SEARCH;
            endcase
            if ($urandom_range(0, 99) < 85) pos = $urandom_range(1, gen_fill > 0 ? gen_fill : 1);
            else pos = $urandom_range(0, 31);
            add_op(act, pick_value(), pos, i == 400 || i == 1000);
            if (act == ACT_PUSH && gen_fill < DEPTH) gen_fill++;
            if (act == ACT_POP && gen_fill > 0) gen_fill--;
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (action_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (3 * DEPTH) @(posedge aclk);

        if (err_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
